/* sv/pwg_pkg.sv */
// shared constants and types for the periodic waveform generator
`timescale 1ns / 1ps
package pwg_pkg;

  localparam int StepDepthDefault = 16;

  // configuration register indexes
  localparam logic [2:0] REG_WAVE_MODE    = 3'd0;
  localparam logic [2:0] REG_PERIOD_TICKS = 3'd1;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd2;
  localparam logic [2:0] REG_LEVEL_SHIFT  = 3'd3;
  localparam logic [2:0] REG_STEP_COUNT   = 3'd4;

  // wave modes
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_SINE     = 3'd1;
  localparam logic [2:0] MODE_SQUARE   = 3'd2;
  localparam logic [2:0] MODE_TRIANGLE = 3'd3;
  localparam logic [2:0] MODE_SAWTOOTH = 3'd4;
  localparam logic [2:0] MODE_STEP     = 3'd5;
  localparam logic [2:0] MODE_CONST    = 3'd6;

  // q1.15 unit and sine polynomial coefficients
  localparam int UnitOne = 32768;
  localparam int SinA    = 51472;
  localparam int SinB    = 21024;
  localparam int SinC    = 2320;

  // divider geometry
  localparam int DivNumW  = 34;
  localparam int DivQuotW = 18;
  localparam int DivDenW  = 16;

  typedef struct packed {
    logic                done;
    logic [DivQuotW-1:0] quot;
    logic [DivDenW-1:0]  rem;
  } pwg_div_res_t;

endpackage

/* sv/pwg_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module pwg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pwg_div.sv */
// bit-serial restoring divider, one dividend bit per cycle
`timescale 1ns / 1ps
module pwg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pwg_pkg::DivNumW-1:0]   dividend_i,
  input  logic [pwg_pkg::DivDenW-1:0]   divisor_i,
  output pwg_pkg::pwg_div_res_t         res_o
);

  localparam int NW = pwg_pkg::DivNumW;
  localparam int DW = pwg_pkg::DivDenW;
  localparam int QW = pwg_pkg::DivQuotW;
  localparam int CW = $clog2(NW);

  logic          active_q, active_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      num_d    = dividend_i;
      den_d    = divisor_i;
      rem_d    = '0;
      quot_d   = '0;
    end else if (active_q) begin
      rem_d  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quot_d = {quot_q[QW-2:0], ge};
      num_d  = {num_q[NW-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

/* sv/periodic_waveform_generator.sv */
// top level of the periodic waveform generator
`timescale 1ns / 1ps
// A tick item (req_type 0) advances the phase counter by delta_ticks modulo the
// active period and returns one sample; a table-write item (req_type 1) stores
// one step level and returns nothing, without leaving idle. Mode, period,
// gain and offset are taken from the registers only at a tick that finds the
// phase at 0. Work is one item at a time: a tick runs the phase modulo on a
// bit-serial divider at one bit per cycle over a 34-bit dividend, plus for
// triangle and sawtooth a second pass through the same divider, for sine
// that pass plus four polynomial steps and for step mode two passes plus a
// table read. Square, const and disabled ticks need no divider pass beyond
// the phase modulo. A finished sample waits in the output register while
// the next item is taken in.
module periodic_waveform_generator #(
  parameter int STEP_DEPTH = pwg_pkg::StepDepthDefault,
  localparam int AW = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [15:0] delta_ticks_i,
  input  logic [3:0]  entry_index_i,
  input  logic signed [15:0] entry_value_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] sample_o
);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_PHASE = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_WAVE  = 4'd4;
  localparam logic [3:0] S_WDIV  = 4'd5;
  localparam logic [3:0] S_SWID  = 4'd6;
  localparam logic [3:0] S_SIDX  = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_RDW   = 4'd9;
  localparam logic [3:0] S_SIN0  = 4'd10;
  localparam logic [3:0] S_SIN1  = 4'd11;
  localparam logic [3:0] S_SIN2  = 4'd12;
  localparam logic [3:0] S_SIN3  = 4'd13;
  localparam logic [3:0] S_SCALE = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  localparam logic [15:0] DEPTH16 = 16'(STEP_DEPTH);

  // pending registers
  logic [2:0]  wave_mode_q;
  logic [15:0] period_ticks_q;
  logic [15:0] amplitude_q;
  logic [15:0] level_shift_q;
  logic [4:0]  step_count_q;

  // active copies and phase
  logic [3:0]  state_q, state_d;
  logic [15:0] phase_q, phase_d;
  logic [2:0]  mode_q, mode_d;
  logic [15:0] period_q, period_d;
  logic [15:0] gain_q, gain_d;
  logic [15:0] offset_q, offset_d;

  // working registers
  logic [15:0] delta_q, delta_d;
  logic [15:0] width_q, width_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [1:0]  quad_q, quad_d;
  logic [14:0] t_q, t_d;
  logic [14:0] z_q, z_d;
  logic [15:0] w_q, w_d;
  logic [16:0] v_q, v_d;
  logic signed [17:0] u_q, u_d;
  logic [15:0] result_q, result_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] sample_q, sample_d;

  // divider hookup
  logic        div_start;
  logic [pwg_pkg::DivNumW-1:0] div_num;
  logic [15:0] div_den;
  pwg_pkg::pwg_div_res_t div_res;

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;

  // ram
  logic        ram_we;
  logic [15:0] ram_rdata;

  // derived values
  logic [15:0] half;
  logic [15:0] n16, nm1;
  logic [16:0] sum;
  logic [15:0] tri_x;
  logic [13:0] ang_r;
  logic [11:0] sin_inner;
  logic [14:0] sin_w2;
  logic [17:0] sin_s;
  logic signed [20:0] scaled;
  logic signed [21:0] acc;
  logic signed [18:0] quot_u;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  assign half  = period_q >> 1;
  assign n16   = ({11'b0, step_count_q} > DEPTH16) ? DEPTH16 : {11'b0, step_count_q};
  assign nm1   = n16 - 16'd1;
  assign sum   = {1'b0, phase_q} + {1'b0, delta_q};
  assign tri_x = (phase_q < half) ? phase_q : (period_q - phase_q);
  assign ang_r = div_res.quot[13:0];
  // unit wave from a scaled quotient, minus one unit
  assign quot_u = signed'({1'b0, div_res.quot}) - 19'sd32768;

  assign prod      = mul_a * mul_b;
  assign sin_inner = prod[25:14];
  assign sin_w2    = prod[28:14];
  assign sin_s     = {1'b0, prod[30:14]};
  // floor toward minus infinity is the arithmetic shift
  assign scaled    = prod[35:15];
  assign acc       = {scaled[20], scaled} + {{6{offset_q[15]}}, offset_q};

  // table writes beyond the depth are dropped
  assign ram_we = in_valid_i && in_ready_o && req_type_i &&
                  ({28'b0, entry_index_i} < 32'(STEP_DEPTH));

  pwg_ram #(
    .WIDTH (16),
    .DEPTH (STEP_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (entry_value_i),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  pwg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .res_o      (div_res)
  );

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SIN0: begin
        mul_a = {3'b0, t_q};
        mul_b = {3'b0, t_q};
      end
      S_SIN1: begin
        mul_a = 18'(pwg_pkg::SinC);
        mul_b = {3'b0, z_q};
      end
      S_SIN2: begin
        mul_a = {2'b0, w_q};
        mul_b = {3'b0, z_q};
      end
      S_SIN3: begin
        mul_a = {1'b0, v_q};
        mul_b = {3'b0, t_q};
      end
      S_SCALE: begin
        mul_a = {{2{gain_q[15]}}, gain_q};
        mul_b = u_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    mode_d      = mode_q;
    period_d    = period_q;
    gain_d      = gain_q;
    offset_d    = offset_q;
    delta_d     = delta_q;
    width_d     = width_q;
    idx_d       = idx_q;
    quad_d      = quad_q;
    t_d         = t_q;
    z_d         = z_q;
    w_d         = w_q;
    v_d         = v_q;
    u_d         = u_q;
    result_d    = result_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = period_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !req_type_i) begin
          delta_d = delta_ticks_i;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // new settings take effect only at the start of a period
        if (phase_q == 16'd0) begin
          mode_d   = wave_mode_q;
          period_d = period_ticks_q;
          gain_d   = amplitude_q;
          offset_d = level_shift_q;
        end
        state_d = S_PHASE;
      end
      S_PHASE: begin
        if (period_q == 16'd0 || phase_q >= period_q) begin
          phase_d = '0;
          state_d = S_WAVE;
        end else begin
          div_start = 1'b1;
          div_num   = {17'b0, sum};
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (div_res.done) begin
          phase_d = div_res.rem;
          state_d = S_WAVE;
        end
      end
      S_WAVE: begin
        result_d = '0;
        state_d  = S_OUT;
        if (period_q != 16'd0) begin
          case (mode_q)
            pwg_pkg::MODE_SINE,
            pwg_pkg::MODE_SAWTOOTH: begin
              div_start = 1'b1;
              div_num   = {2'b0, phase_q, 16'b0};
              state_d   = S_WDIV;
            end
            pwg_pkg::MODE_TRIANGLE: begin
              div_start = 1'b1;
              div_num   = {1'b0, tri_x, 17'b0};
              state_d   = S_WDIV;
            end
            pwg_pkg::MODE_SQUARE: begin
              u_d     = (phase_q < half) ? -18'sd32768 : 18'sd32768;
              state_d = S_SCALE;
            end
            pwg_pkg::MODE_STEP: begin
              // empty table gives zero
              if (n16 != 16'd0) begin
                div_start = 1'b1;
                div_num   = {18'b0, period_q};
                div_den   = n16;
                state_d   = S_SWID;
              end
            end
            pwg_pkg::MODE_CONST: begin
              result_d = gain_q;
            end
            default: begin
              result_d = '0;
            end
          endcase
        end
      end
      S_WDIV: begin
        if (div_res.done) begin
          if (mode_q == pwg_pkg::MODE_SINE) begin
            quad_d  = div_res.quot[15:14];
            t_d     = div_res.quot[14] ? (15'd16384 - {1'b0, ang_r}) : {1'b0, ang_r};
            state_d = S_SIN0;
          end else begin
            u_d     = quot_u[17:0];
            state_d = S_SCALE;
          end
        end
      end
      S_SWID: begin
        if (div_res.done) begin
          width_d = div_res.quot[15:0];
          if (div_res.quot[15:0] == 16'd0) begin
            idx_d   = AW'(nm1);
            state_d = S_RD;
          end else begin
            div_start = 1'b1;
            div_num   = {18'b0, phase_q};
            div_den   = div_res.quot[15:0];
            state_d   = S_SIDX;
          end
        end
      end
      S_SIDX: begin
        if (div_res.done) begin
          // past the last step holds the last level
          if (div_res.quot > {2'b0, nm1}) begin
            idx_d = AW'(nm1);
          end else begin
            idx_d = AW'(div_res.quot);
          end
          state_d = S_RD;
        end
        div_den = width_q;
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        u_d     = {{2{ram_rdata[15]}}, ram_rdata};
        state_d = S_SCALE;
      end
      S_SIN0: begin
        z_d     = prod[28:14];
        state_d = S_SIN1;
      end
      S_SIN1: begin
        w_d     = 16'(pwg_pkg::SinB) - {4'b0, sin_inner};
        state_d = S_SIN2;
      end
      S_SIN2: begin
        v_d     = 17'(pwg_pkg::SinA) - {2'b0, sin_w2};
        state_d = S_SIN3;
      end
      S_SIN3: begin
        u_d     = quad_q[1] ? (18'sd0 - signed'(sin_s)) : signed'(sin_s);
        state_d = S_SCALE;
      end
      S_SCALE: begin
        if (acc > 22'sd32767) begin
          result_d = 16'h7fff;
        end else if (acc < -22'sd32768) begin
          result_d = 16'h8000;
        end else begin
          result_d = acc[15:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          sample_d    = result_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_mode_q    <= '0;
      period_ticks_q <= '0;
      amplitude_q    <= '0;
      level_shift_q  <= '0;
      step_count_q   <= '0;
      state_q        <= S_IDLE;
      phase_q        <= '0;
      mode_q         <= '0;
      period_q       <= '0;
      gain_q         <= '0;
      offset_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pwg_pkg::REG_WAVE_MODE:    wave_mode_q    <= cfg_data_i[2:0];
          pwg_pkg::REG_PERIOD_TICKS: period_ticks_q <= cfg_data_i;
          pwg_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_data_i;
          pwg_pkg::REG_LEVEL_SHIFT:  level_shift_q  <= cfg_data_i;
          pwg_pkg::REG_STEP_COUNT:   step_count_q   <= cfg_data_i[4:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      phase_q     <= phase_d;
      mode_q      <= mode_d;
      period_q    <= period_d;
      gain_q      <= gain_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    width_q  <= width_d;
    idx_q    <= idx_d;
    quad_q   <= quad_d;
    t_q      <= t_d;
    z_q      <= z_d;
    w_q      <= w_d;
    v_q      <= v_d;
    u_q      <= u_d;
    result_q <= result_d;
    sample_q <= sample_d;
  end

endmodule

/* tb/pwg_checker.sv */
// checker for the periodic waveform generator: tracks state, predicts and compares samples
`timescale 1ns / 1ps
module pwg_checker
  import pwg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               req_type_i,
  input  logic [15:0]        delta_ticks_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [15:0] entry_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] sample_i,
  output int                 errors_o,
  output int                 pending_o,
  output logic [15:0]        phase_o,
  output logic [15:0]        period_o
);

  // pending registers
  logic [2:0]         pend_mode;
  logic [15:0]        pend_period;
  logic signed [15:0] pend_gain;
  logic signed [15:0] pend_offset;
  logic [4:0]         steps_used;

  // active copies and phase
  logic [15:0]        phase;
  logic [2:0]         act_mode;
  logic [15:0]        act_period;
  logic signed [15:0] act_gain;
  logic signed [15:0] act_offset;
  logic signed [15:0] levels [StepDepthDefault];

  logic signed [15:0] sample_q [$];

  assign pending_o = sample_q.size();
  assign phase_o   = phase;
  assign period_o  = act_period;

  function automatic longint sine_of(input logic [15:0] angle);
    int unsigned quad, r, t, z2, inner, w, w2, v, s;
    quad  = angle[15:14];
    r     = angle[13:0];
    t     = quad[0] ? (16384 - r) : r;
    z2    = (t * t) >> 14;
    inner = (SinC * z2) >> 14;
    w     = SinB - inner;
    w2    = (w * z2) >> 14;
    v     = SinA - w2;
    s     = (v * t) >> 14;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic signed [15:0] wave_sample();
    longint unsigned p, pr, half, n, width, idx;
    longint u, scaled;
    p    = phase;
    pr   = act_period;
    half = pr / 2;
    if (pr == 0) return '0;
    case (act_mode)
      MODE_SINE:     u = sine_of(16'((p * 65536) / pr));
      MODE_SQUARE:   u = (p < half) ? -UnitOne : UnitOne;
      MODE_TRIANGLE: begin
        if (p < half) u = longint'((4 * UnitOne * p) / pr) - UnitOne;
        else u = longint'((4 * UnitOne * (pr - p)) / pr) - UnitOne;
      end
      MODE_SAWTOOTH: u = longint'((2 * UnitOne * p) / pr) - UnitOne;
      MODE_STEP: begin
        n = (steps_used > StepDepthDefault) ? StepDepthDefault : steps_used;
        if (n == 0) return '0;
        width = pr / n;
        idx = (width == 0) ? n - 1 : p / width;
        if (idx > n - 1) idx = n - 1;
        u = levels[idx];
      end
      MODE_CONST:    return act_gain;
      default:       return '0;
    endcase
    // floor of gain * u / 2^15, then offset and saturation
    scaled = ((longint'(act_gain) * u) >>> 15) + longint'(act_offset);
    if (scaled > 32767) return 16'sd32767;
    if (scaled < -32768) return -16'sd32768;
    return 16'(scaled);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned sum;
    logic signed [15:0] want;
    if (!rst_ni) begin
      pend_mode   = MODE_NONE;
      pend_period = '0;
      pend_gain   = '0;
      pend_offset = '0;
      steps_used  = '0;
      phase       = '0;
      act_mode    = MODE_NONE;
      act_period  = '0;
      act_gain    = '0;
      act_offset  = '0;
      errors_o    = 0;
      sample_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WAVE_MODE:    pend_mode   = cfg_data_i[2:0];
          REG_PERIOD_TICKS: pend_period = cfg_data_i;
          REG_AMPLITUDE:    pend_gain   = cfg_data_i;
          REG_LEVEL_SHIFT:  pend_offset = cfg_data_i;
          REG_STEP_COUNT:   steps_used  = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (sample_q.size() == 0) begin
          $error("sample with nothing expected: got %0d", sample_i);
          errors_o++;
        end else begin
          want = sample_q.pop_front();
          if (sample_i !== want) begin
            $error("sample: expected %0d, got %0d", want, sample_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i) begin
          levels[entry_index_i] = entry_value_i;
        end else begin
          if (phase == 0) begin
            act_mode   = pend_mode;
            act_period = pend_period;
            act_gain   = pend_gain;
            act_offset = pend_offset;
          end
          if (act_period == 0 || phase >= act_period) phase = '0;
          else begin
            sum   = phase + delta_ticks_i;
            phase = 16'(sum % act_period);
          end
          sample_q.push_back(wave_sample());
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
// top of the periodic waveform generator testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module testbench;
  import pwg_pkg::*;

  localparam logic [2:0] REG_OUT_OF_MAP = 3'd7;  // no register there, write is dropped
  localparam int SettleCycles = 200;            // covers the slowest step-mode tick
  localparam int CycleLimit   = 1000000;
  localparam int ItemTarget   = 1100;
  localparam int QuietFrom    = 950;            // no random idling past this item count

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               req_type_i = 1'b0;
  logic [15:0]        delta_ticks_i = '0;
  logic [3:0]         entry_index_i = '0;
  logic signed [15:0] entry_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] sample_o;

  int          errors, pending;
  logic [15:0] phase_now, period_now;
  int          items_sent = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;   // ask the receiver for one long stall
  bit          hold_taken = 1'b0;

  always #5 clk_i = ~clk_i;

  periodic_waveform_generator dut (.*);

  pwg_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .delta_ticks_i,
    .entry_index_i, .entry_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .sample_i(sample_o),
    .errors_o(errors), .pending_o(pending), .phase_o(phase_now), .period_o(period_now)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: short random stalls, plus one long stall on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        // long stall, counted here, while the sender keeps offering items
        out_ready_i <= 1'b0;
        hold_taken = 1'b1;
        repeat (399) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // offer one item and hold it until taken
  task automatic send(input logic kind, input logic [15:0] delta,
                      input logic [3:0] idx, input logic [15:0] level);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    delta_ticks_i <= delta;
    entry_index_i <= idx;
    entry_value_i <= level;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
    end
  endtask

  // drain: input idle, every sample back, then room for a table write in flight
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // one setting: program registers, bring phase to 0 so they load, then run ticks and table writes
  task automatic run_setting(input logic [2:0] mode, input logic [15:0] per,
                             input logic [15:0] gain, input logic [15:0] offs,
                             input logic [4:0] steps, input int count, input int max_delta);
    logic [15:0] delta;
    settle();
    cfg_write(REG_WAVE_MODE, {13'd0, mode});
    cfg_write(REG_PERIOD_TICKS, per);
    cfg_write(REG_AMPLITUDE, gain);
    cfg_write(REG_LEVEL_SHIFT, offs);
    cfg_write(REG_STEP_COUNT, {11'd0, steps});
    if (period_now != 0 && phase_now != 0)
      send(1'b0, period_now - phase_now, '0, '0);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        send(1'b1, 16'($urandom), 4'($urandom), 16'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       delta = 16'($urandom);
          1:       delta = '0;
          default: delta = 16'($urandom_range(0, max_delta));
        endcase
        send(1'b0, delta, 4'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] per;
    logic [15:0] gain, offs;
    int          span;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the whole step table first so no unwritten entry is ever read
    send(1'b1, 16'hffff, 4'd0, -16'sd32768);
    send(1'b1, '0, 4'd15, 16'sd32767);
    for (int i = 1; i < 15; i++) send(1'b1, 16'($urandom), 4'(i), 16'($urandom));
    // input goes idle before any register write
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    cfg_write(REG_OUT_OF_MAP, 16'hffff);

    // directed settings: each mode, extremes, special cases
    run_setting(MODE_SINE, 16'hffff, 16'h7fff, 16'h0000, 5'd0, 4, 16'hffff);
    run_setting(MODE_SQUARE, 16'd2, 16'h8000, 16'h7fff, 5'd0, 3, 1);
    run_setting(MODE_TRIANGLE, 16'd7, 16'h7fff, 16'h7fff, 5'd0, 4, 3);
    run_setting(MODE_SAWTOOTH, 16'd1, 16'h8000, 16'h8000, 5'd0, 2, 2);
    run_setting(MODE_STEP, 16'd9, 16'h7fff, 16'h0000, 5'd0, 2, 3);    // empty table
    run_setting(MODE_STEP, 16'd5, 16'h8000, 16'h0000, 5'd16, 3, 2);   // width zero
    run_setting(MODE_STEP, 16'd40, 16'h7fff, 16'h8000, 5'd31, 3, 20); // count above depth
    run_setting(MODE_CONST, 16'd3, 16'h8000, 16'h1234, 5'd0, 2, 1);
    run_setting(MODE_CONST, 16'd0, 16'h7fff, 16'h1234, 5'd0, 2, 5);   // period zero
    run_setting(3'd7, 16'd4, 16'h7fff, 16'h7fff, 5'd0, 2, 3);
    run_setting(MODE_NONE, 16'd4, 16'h7fff, 16'h7fff, 5'd0, 1, 3);

    // random settings, mostly short periods so the phase wraps often
    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        0:       per = '0;
        1, 2:    per = 16'($urandom);
        default: per = 16'($urandom_range(1, 40));
      endcase
      gain = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
                                         : 16'($urandom);
      offs = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
                                         : 16'($urandom);
      span = (per == 0) ? 100 : 3 * per;
      if (span > 65535) span = 65535;
      if (items_sent > QuietFrom) quiet = 1'b1;
      if (items_sent > 400) hold_req = 1'b1;
      run_setting(3'($urandom), per, gain, offs, 5'($urandom), 30, span);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
